/* rtl/core/dctl_pkg.sv */
// ----------------------------------------------------------------------------
// dctl_pkg: shared types and constants for the device capture table
// Widths of the item fields, operation codes and the front-to-back command.
// ----------------------------------------------------------------------------
package dctl_pkg;

  localparam int DEVICE_SLOTS_DEF = 8;
  localparam int SAMPLES_DEF      = 2;
  localparam int PAYLOAD_MAX_DEF  = 31;
  localparam int WORDS_PER_SAMPLE = 4;
  localparam int LEN_CAP_HW       = 31;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_FORGET = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] mac;
    logic [7:0]  rssi;
    logic [31:0] timestamp;
    logic [7:0]  length;
    logic [63:0] payload_word;
    logic [1:0]  word_index;
    logic [2:0]  read_slot;
    logic        read_sample;
  } item_t;

  typedef struct packed {
    logic [2:0]  slot;
    logic        was_new;
    logic        evicted;
    logic        entry_valid;
    logic [47:0] mac_out;
    logic [31:0] last_seen_out;
    logic [1:0]  sample_count;
    logic [4:0]  sample_len;
    logic [7:0]  sample_rssi;
    logic [31:0] sample_time;
    logic [63:0] sample_word;
  } result_t;

  // Mask of the bytes below len within payload word w.
  function automatic logic [63:0] byte_mask(input logic [4:0] len, input logic [1:0] w);
    logic [5:0] first;
    logic [5:0] n;
    logic [63:0] m;
    first = {1'b0, w, 3'b000};
    m = '0;
    if ({1'b0, len} > first) begin
      n = {1'b0, len} - first;
      for (int b = 0; b < 8; b++) begin
        if (6'(b) < n) m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

/* rtl/core/device_capture_table_lru_core.sv */
// ----------------------------------------------------------------------------
// device_capture_table_lru_core: LRU evicting device address table
// Tracks devices by MAC with a rolling window of samples per device.
// ----------------------------------------------------------------------------
// Input channel: push/full with in_* fields. Kind 0 adds a payload word (word 0
// opens a sample and looks the MAC up), kind 1 forgets a device, kind 2 reads
// a slot and sample. Result channel: empty/pop with out_* fields; every item
// yields exactly one result, and kind 3 yields an all-zero result.
// In the engine an item passes a lookup phase for the parallel MAC compare,
// free-slot and oldest-slot search and the payload read, then a write-back
// phase for the table.
// The engine works on one item at a time and takes the next only after the
// write-back of the last.
// A two-entry queue sits between input stage and engine, and a two-entry
// result queue follows the engine; when the receiver stalls, the engine halts
// once the result queue is full and full rises once the input queue fills.
// Reset empties both queues and clears every slot and sample.
// ----------------------------------------------------------------------------
module device_capture_table_lru_core #(
  parameter int DEVICE_SLOTS       = dctl_pkg::DEVICE_SLOTS_DEF,
  parameter int SAMPLES_PER_DEVICE = dctl_pkg::SAMPLES_DEF,
  parameter int PAYLOAD_BYTES_MAX  = dctl_pkg::PAYLOAD_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_kind,
  input  logic [47:0] in_mac,
  input  logic signed [7:0] in_rssi,
  input  logic [31:0] in_timestamp,
  input  logic [7:0]  in_length,
  input  logic [63:0] in_payload_word,
  input  logic [1:0]  in_word_index,
  input  logic [2:0]  in_read_slot,
  input  logic        in_read_sample,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_slot,
  output logic        out_was_new,
  output logic        out_evicted,
  output logic        out_entry_valid,
  output logic [47:0] out_mac_out,
  output logic [31:0] out_last_seen_out,
  output logic [1:0]  out_sample_count,
  output logic [4:0]  out_sample_len,
  output logic signed [7:0] out_sample_rssi,
  output logic [31:0] out_sample_time,
  output logic [63:0] out_sample_word
);
  import dctl_pkg::*;

  item_t   item_in, cmd;
  result_t res;
  logic    cmd_valid, cmd_take;

  assign item_in = '{kind: in_kind, mac: in_mac, rssi: in_rssi, timestamp: in_timestamp,
                     length: in_length, payload_word: in_payload_word,
                     word_index: in_word_index, read_slot: in_read_slot,
                     read_sample: in_read_sample};

  dctl_front #(.PAYLOAD_BYTES_MAX(PAYLOAD_BYTES_MAX)) u_front (
    .clk, .rst_n, .push, .full, .item_in, .cmd_valid, .cmd_take, .cmd
  );

  dctl_back #(.DEVICE_SLOTS(DEVICE_SLOTS), .SAMPLES_PER_DEVICE(SAMPLES_PER_DEVICE)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd, .empty, .pop, .res
  );

  assign out_slot          = res.slot;
  assign out_was_new       = res.was_new;
  assign out_evicted       = res.evicted;
  assign out_entry_valid   = res.entry_valid;
  assign out_mac_out       = res.mac_out;
  assign out_last_seen_out = res.last_seen_out;
  assign out_sample_count  = res.sample_count;
  assign out_sample_len    = res.sample_len;
  assign out_sample_rssi   = res.sample_rssi;
  assign out_sample_time   = res.sample_time;
  assign out_sample_word   = res.sample_word;

endmodule

/* rtl/core/dctl_front.sv */
// ----------------------------------------------------------------------------
// dctl_front: input stage
// Accepts items, clamps the length and holds them in a short queue for the
// back end.
// ----------------------------------------------------------------------------
module dctl_front #(
  parameter int PAYLOAD_BYTES_MAX = dctl_pkg::PAYLOAD_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  output logic           full,
  input  dctl_pkg::item_t item_in,
  output logic           cmd_valid,
  input  logic           cmd_take,
  output dctl_pkg::item_t cmd
);
  import dctl_pkg::*;

  localparam int CAP = (PAYLOAD_BYTES_MAX > LEN_CAP_HW) ? LEN_CAP_HW : PAYLOAD_BYTES_MAX;

  item_t      q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  item_t      clamped;

  always_comb begin
    clamped = item_in;
    if (item_in.length > 8'(CAP)) clamped.length = 8'(CAP);
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (cmd_take && cmd_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push && !full) - 2'(cmd_take && cmd_valid);
    end
    if (push && !full) q_r[wp_r] <= clamped;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !cmd_valid)
    else $error("command shown from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> (cnt_r == $past(cnt_r) - 2'($past(cmd_take))))
    else $error("push taken while full");

endmodule

/* rtl/core/dctl_back.sv */
// ----------------------------------------------------------------------------
// dctl_back: table engine
// Carries out add, forget and read on the slot table and sample store, and
// holds results in an output queue.
// ----------------------------------------------------------------------------
module dctl_back #(
  parameter int DEVICE_SLOTS       = dctl_pkg::DEVICE_SLOTS_DEF,
  parameter int SAMPLES_PER_DEVICE = dctl_pkg::SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  output logic             cmd_take,
  input  dctl_pkg::item_t  cmd,
  output logic             empty,
  input  logic             pop,
  output dctl_pkg::result_t res
);
  import dctl_pkg::*;

  localparam int SW    = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam int PW    = (SAMPLES_PER_DEVICE > 1) ? $clog2(SAMPLES_PER_DEVICE) : 1;
  localparam int CW    = $clog2(SAMPLES_PER_DEVICE + 1);
  localparam int NWORD = DEVICE_SLOTS * SAMPLES_PER_DEVICE * WORDS_PER_SAMPLE;
  localparam int AW    = $clog2(NWORD);

  logic              used_r  [DEVICE_SLOTS];
  logic [47:0]       mac_r   [DEVICE_SLOTS];
  logic [31:0]       seen_r  [DEVICE_SLOTS];
  logic [CW-1:0]     cnt_r   [DEVICE_SLOTS];
  logic [4:0]        slen_r  [DEVICE_SLOTS][SAMPLES_PER_DEVICE];
  logic [7:0]        srssi_r [DEVICE_SLOTS][SAMPLES_PER_DEVICE];
  logic [31:0]       stime_r [DEVICE_SLOTS][SAMPLES_PER_DEVICE];
  logic [SW-1:0]     cur_slot_r;
  logic [PW-1:0]     cur_pos_r;

  // Payload words live in a memory; each window position maps to a physical
  // sample, and a written flag per word makes unwritten words read as zero.
  logic [PW-1:0]     map_r   [DEVICE_SLOTS][SAMPLES_PER_DEVICE];
  logic              wv_r    [DEVICE_SLOTS][SAMPLES_PER_DEVICE][WORDS_PER_SAMPLE];
  logic [63:0]       pay_mem [NWORD];
  logic [63:0]       rdata_r;
  logic [AW-1:0]     raddr, waddr;
  logic [63:0]       wdata;
  logic              mem_we;
  logic [PW-1:0]     rphys, wphys, cphys;

  // Output queue
  result_t    oq_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       opush;

  // Two-phase engine: phase 0 looks up and picks the victim, phase 1 writes.
  logic          ph_r;
  logic          hit_r, free_r;
  logic [SW-1:0] hslot_r, fslot_r, oslot_r;

  logic          hit_c, free_c;
  logic [SW-1:0] hslot_c, fslot_c, oslot_c;
  logic [31:0]   omin_c;

  function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] s,
                                              input logic [PW-1:0] p,
                                              input logic [1:0] w);
    return AW'((int'(s) * SAMPLES_PER_DEVICE + int'(p)) * WORDS_PER_SAMPLE + int'(w));
  endfunction

  always_comb begin
    hit_c = 1'b0; hslot_c = '0; free_c = 1'b0; fslot_c = '0;
    oslot_c = '0; omin_c = seen_r[0];
    for (int i = DEVICE_SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && mac_r[i] == cmd.mac) begin
        hit_c = 1'b1; hslot_c = SW'(i);
      end
      if (!used_r[i]) begin
        free_c = 1'b1; fslot_c = SW'(i);
      end
    end
    for (int i = 1; i < DEVICE_SLOTS; i++) begin
      if (seen_r[i] < omin_c) begin
        omin_c = seen_r[i]; oslot_c = SW'(i);
      end
    end
  end

  assign cmd_take = cmd_valid && ph_r && (ocnt_r != 2'd2);
  assign opush    = cmd_take;
  assign empty    = (ocnt_r == 2'd0);
  assign res      = oq_r[orp_r];

  logic          is_add0, is_addn, rd_ok;
  logic [SW-1:0] e;
  logic [CW-1:0] ecnt;
  logic [PW-1:0] pos;
  logic          shift;
  logic [SW-1:0] rs;
  logic [PW-1:0] rp;
  result_t       r;

  always_comb begin
    is_add0 = cmd.kind == KIND_ADD && cmd.word_index == 2'd0;
    is_addn = cmd.kind == KIND_ADD && cmd.word_index != 2'd0;
    e       = hit_r ? hslot_r : (free_r ? fslot_r : oslot_r);
    ecnt    = hit_r ? cnt_r[e] : '0;
    shift   = ecnt >= CW'(SAMPLES_PER_DEVICE);
    pos     = shift ? PW'(SAMPLES_PER_DEVICE - 1) : PW'(ecnt);
    rs      = SW'(cmd.read_slot);
    rp      = PW'(cmd.read_sample);
    rphys   = map_r[rs][rp];
    rd_ok   = (32'(cmd.read_slot) < DEVICE_SLOTS);
    r = '0;
    case (cmd.kind)
      KIND_ADD: begin
        if (is_add0) begin
          r.slot        = 3'(e);
          r.was_new     = !hit_r;
          r.evicted     = !hit_r && !free_r;
          r.entry_valid = 1'b1;
        end else begin
          r.slot        = 3'(cur_slot_r);
          r.entry_valid = used_r[cur_slot_r] && (CW'(cur_pos_r) < cnt_r[cur_slot_r]);
        end
      end
      KIND_FORGET: begin
        if (hit_r) begin
          r.slot        = 3'(hslot_r);
          r.entry_valid = 1'b1;
        end
      end
      KIND_READ: begin
        r.slot = cmd.read_slot;
        if (rd_ok) begin
          r.entry_valid   = used_r[rs];
          r.mac_out       = mac_r[rs];
          r.last_seen_out = seen_r[rs];
          r.sample_count  = 2'(cnt_r[rs]);
          if (32'(cmd.read_sample) < SAMPLES_PER_DEVICE &&
              CW'(cmd.read_sample) < cnt_r[rs]) begin
            r.sample_len  = slen_r[rs][rp];
            r.sample_rssi = srssi_r[rs][rp];
            r.sample_time = stime_r[rs][rp];
            r.sample_word = wv_r[rs][rphys][cmd.word_index] ? rdata_r : '0;
          end
        end
      end
      default: r = '0;
    endcase
  end

  // Write port: word 0 of a new sample, or a later word of the open sample
  always_comb begin
    wphys  = shift ? map_r[e][0] : map_r[e][pos];
    cphys  = map_r[cur_slot_r][cur_pos_r];
    raddr  = word_addr(rs, rphys, cmd.word_index);
    mem_we = cmd_take && (is_add0 || (is_addn && r.entry_valid));
    if (is_add0) begin
      waddr = word_addr(e, wphys, 2'd0);
      wdata = cmd.payload_word & byte_mask(5'(cmd.length), 2'd0);
    end else begin
      waddr = word_addr(cur_slot_r, cphys, cmd.word_index);
      wdata = cmd.payload_word &
              byte_mask(slen_r[cur_slot_r][cur_pos_r], cmd.word_index);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) pay_mem[waddr] <= wdata;
    // read in the lookup phase; the store is only written in the next phase
    if (cmd_valid && !ph_r) rdata_r <= pay_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r       <= 1'b0;
      owp_r      <= 1'b0;
      orp_r      <= 1'b0;
      ocnt_r     <= '0;
      cur_slot_r <= '0;
      cur_pos_r  <= '0;
      for (int i = 0; i < DEVICE_SLOTS; i++) begin
        used_r[i] <= 1'b0;
        mac_r[i]  <= '0;
        seen_r[i] <= '0;
        cnt_r[i]  <= '0;
        for (int p = 0; p < SAMPLES_PER_DEVICE; p++) begin
          slen_r[i][p]  <= '0;
          srssi_r[i][p] <= '0;
          stime_r[i][p] <= '0;
          map_r[i][p]   <= PW'(p);
          for (int w = 0; w < WORDS_PER_SAMPLE; w++) wv_r[i][p][w] <= 1'b0;
        end
      end
    end else begin
      if (cmd_valid && !ph_r) begin
        ph_r    <= 1'b1;
        hit_r   <= hit_c;
        hslot_r <= hslot_c;
        free_r  <= free_c;
        fslot_r <= fslot_c;
        oslot_r <= oslot_c;
      end
      if (cmd_take) begin
        ph_r <= 1'b0;
        if (is_add0) begin
          if (!hit_r) begin
            used_r[e] <= 1'b1;
            mac_r[e]  <= cmd.mac;
            for (int p = 0; p < SAMPLES_PER_DEVICE; p++) begin
              slen_r[e][p]  <= '0;
              srssi_r[e][p] <= '0;
              stime_r[e][p] <= '0;
            end
          end else if (shift) begin
            // drop the oldest sample, recycle its payload words for the new one
            for (int p = 0; p + 1 < SAMPLES_PER_DEVICE; p++) begin
              slen_r[e][p]  <= slen_r[e][p+1];
              srssi_r[e][p] <= srssi_r[e][p+1];
              stime_r[e][p] <= stime_r[e][p+1];
              map_r[e][p]   <= map_r[e][p+1];
            end
            map_r[e][SAMPLES_PER_DEVICE-1] <= map_r[e][0];
          end
          seen_r[e]       <= cmd.timestamp;
          cnt_r[e]        <= CW'(pos) + CW'(1);
          slen_r[e][pos]  <= 5'(cmd.length);
          srssi_r[e][pos] <= cmd.rssi;
          stime_r[e][pos] <= cmd.timestamp;
          wv_r[e][wphys][0] <= 1'b1;
          for (int w = 1; w < WORDS_PER_SAMPLE; w++) wv_r[e][wphys][w] <= 1'b0;
          cur_slot_r <= e;
          cur_pos_r  <= pos;
        end else if (is_addn && r.entry_valid) begin
          wv_r[cur_slot_r][cphys][cmd.word_index] <= 1'b1;
        end else if (cmd.kind == KIND_FORGET && hit_r) begin
          used_r[hslot_r] <= 1'b0;
          mac_r[hslot_r]  <= '0;
          seen_r[hslot_r] <= '0;
          cnt_r[hslot_r]  <= '0;
          for (int p = 0; p < SAMPLES_PER_DEVICE; p++) begin
            slen_r[hslot_r][p]  <= '0;
            srssi_r[hslot_r][p] <= '0;
            stime_r[hslot_r][p] <= '0;
          end
        end
      end
      if (opush) owp_r <= ~owp_r;
      if (pop && !empty) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + 2'(opush) - 2'(pop && !empty);
    end
    if (opush) oq_r[owp_r] <= r;
  end

  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= 2'd2)
    else $error("result queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_take |-> ph_r)
    else $error("command retired before lookup");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_take |=> !ph_r)
    else $error("engine phase not restarted");
  assert property (@(posedge clk) disable iff (!rst_n)
    (opush && is_add0) |-> (r.entry_valid && !(r.evicted && !r.was_new)))
    else $error("inconsistent add result");

endmodule
